// ===== rtl/core/message_fragment_framer_core_defines.svh =====
// Assertion macros shared by the framer modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef MESSAGE_FRAGMENT_FRAMER_CORE_DEFINES_SVH
`define MESSAGE_FRAGMENT_FRAMER_CORE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MFF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mff_pkg;

  // Request commands.
  localparam logic CmdStart = 1'b0;
  localparam logic CmdData  = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusZeroLen = 2'd1;
  localparam logic [1:0] StatusNoMsg   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHost   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClient = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDepth  = 2'd2;

  // Header layout.
  localparam int unsigned FragLenW = 9;
  localparam int unsigned AddrW    = 8;
  localparam logic [FragLenW-1:0] FragLenCap = '1;
  localparam logic [AddrW-1:0] DepthReset = 8'd128;
  localparam logic [AddrW-1:0] DepthMin   = 8'd2;

  // Queue between the front and back parts; depth is a power of two.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // One queue entry holds all results of one request (one or two).
  typedef struct packed {
    logic [31:0] word0;
    logic        hdr0;
    logic        end0;
    logic [1:0]  status0;
    logic        two;
    logic [31:0] word1;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/message_fragment_framer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_stall_o    command_i, message_length_i, data_byte_i
// out       result     out_valid_o / out_stall_i  slot_word_o, is_header_o, message_end_o,
//                                                 status_o, last_o
// cfg       write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One request is accepted per cycle unless the queue is full; its results pass the queue
// and then the output register. A request that ends a fragment short of the message end
// gives two results, the data word and then the header, which leave one after the other.
// A four-entry queue between the classifying front and the output stage absorbs that,
// so the input stalls only while the queue is full.
// Reset clears the framing state, the queue and the output register; the depth
// register resets to 128 slots and both addresses to zero.

module message_fragment_framer_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mff_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [15:0]                 message_length_i,
  input  wire logic [7:0]                  data_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [31:0]                      slot_word_o,
  output logic                             is_header_o,
  output logic                             message_end_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  logic            q_full, q_empty, q_push, q_pop;
  mff_pkg::entry_t q_entry, q_head;

  // Front: accepts requests, tracks the framing state, builds queue entries.
  mff_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .message_length_i (message_length_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (q_entry)
  );

  // Queue of pending result groups.
  mff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back: emits the results of each entry one per cycle while the output is not stalled.
  mff_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slot_word_o   (slot_word_o),
    .is_header_o   (is_header_o),
    .message_end_o (message_end_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mff_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mff_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mff_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic [15:0]                  message_length_i,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output mff_pkg::entry_t                   q_entry_o
);

  localparam int unsigned FW = mff_pkg::FragLenW;

  logic [7:0]             host_q, client_q, depth_q;
  logic                   open_q, open_d;
  logic [LENGTH_BITS-1:0] total_q, total_d;
  logic [FW-1:0]          frag_q, frag_d;
  logic [23:0]            acc_q, acc_d;
  logic [1:0]             pos_q, pos_d;

  logic                   accept;
  logic [LENGTH_BITS-1:0] total_start, total_dec, hdr_total;
  logic [FW-1:0]          frag_dec, lim, hdr_frag;
  logic [7:0]             depth_eff;
  logic [FW:0]            room, room_cap;
  logic                   hdr_complete;
  logic [31:0]            hdr_word, data_word;
  logic                   frag_done, msg_done;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q   <= '0;
      client_q <= '0;
      depth_q  <= mff_pkg::DepthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mff_pkg::CfgHost:   host_q   <= cfg_data_i;
        mff_pkg::CfgClient: client_q <= cfg_data_i;
        mff_pkg::CfgDepth:  depth_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Fragment limit: min(max(depth, 2) * 4, 511) - 4.
  assign depth_eff = (depth_q < mff_pkg::DepthMin) ? mff_pkg::DepthMin : depth_q;
  assign room      = {depth_eff, 2'b00};
  assign room_cap  = (room < {1'b0, mff_pkg::FragLenCap}) ? room
                                                          : {1'b0, mff_pkg::FragLenCap};
  assign lim       = FW'(room_cap - (FW+1)'(4));

  // Byte counters and the header of the next fragment.
  assign total_start = LENGTH_BITS'(message_length_i);
  assign total_dec   = total_q - 1'b1;
  assign frag_dec    = frag_q - 1'b1;
  assign frag_done   = (frag_dec == '0);
  assign msg_done    = (total_dec == '0);
  assign hdr_total   = (command_i == mff_pkg::CmdStart) ? total_start : total_dec;
  assign hdr_frag    = (hdr_total < LENGTH_BITS'(lim)) ? FW'(hdr_total) : lim;
  assign hdr_complete = (LENGTH_BITS'(hdr_frag) == hdr_total);
  assign hdr_word    = {hdr_complete, 6'd0, hdr_frag, host_q, client_q};

  // Little-endian packing of the incoming byte.
  assign data_word = {8'd0, acc_q} | (32'(data_byte_i) << {pos_q, 3'b000});

  // Classify the request and update the framing state.
  always_comb begin
    open_d    = open_q;
    total_d   = total_q;
    frag_d    = frag_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    q_push_o  = 1'b0;
    q_entry_o = '0;
    if (accept) begin
      if (command_i == mff_pkg::CmdStart) begin
        open_d   = 1'b0;
        total_d  = '0;
        frag_d   = '0;
        acc_d    = '0;
        pos_d    = '0;
        q_push_o = 1'b1;
        if (total_start == '0) begin
          q_entry_o.status0 = mff_pkg::StatusZeroLen;
        end else begin
          open_d          = 1'b1;
          total_d         = total_start;
          frag_d          = hdr_frag;
          q_entry_o.word0 = hdr_word;
          q_entry_o.hdr0  = 1'b1;
        end
      end else if (!open_q) begin
        q_push_o          = 1'b1;
        q_entry_o.status0 = mff_pkg::StatusNoMsg;
      end else begin
        total_d = total_dec;
        frag_d  = frag_dec;
        if (pos_q == 2'd3 || frag_done) begin
          q_push_o        = 1'b1;
          q_entry_o.word0 = data_word;
          q_entry_o.end0  = msg_done;
          acc_d           = '0;
          pos_d           = '0;
          if (msg_done) begin
            open_d = 1'b0;
            frag_d = '0;
          end else if (frag_done) begin
            q_entry_o.two   = 1'b1;
            q_entry_o.word1 = hdr_word;
            frag_d          = hdr_frag;
          end
        end else begin
          acc_d = data_word[23:0];
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      total_q <= '0;
      frag_q  <= '0;
      acc_q   <= '0;
      pos_q   <= '0;
    end else begin
      open_q  <= open_d;
      total_q <= total_d;
      frag_q  <= frag_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mff_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "message_fragment_framer_core_defines.svh"

module mff_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mff_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output mff_pkg::entry_t       head_o
);

  mff_pkg::entry_t                mem_q [mff_pkg::QDepth];
  logic [mff_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [mff_pkg::QCntW-1:0]      cnt_q;

  assign full_o  = (cnt_q == mff_pkg::QCntW'(mff_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `MFF_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full queue")
  `MFF_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from an empty queue")
  `MFF_ASSERT(a_cnt_bound, cnt_q <= mff_pkg::QCntW'(mff_pkg::QDepth), "fill count above depth")

endmodule

`default_nettype wire

// ===== rtl/core/mff_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "message_fragment_framer_core_defines.svh"

module mff_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire mff_pkg::entry_t  q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [31:0]           slot_word_o,
  output logic                  is_header_o,
  output logic                  message_end_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  logic        valid_q, valid_d;
  logic        sel_q, sel_d;
  logic        load;
  logic [31:0] word_q;
  logic        hdr_q, end_q, last_q;
  logic [1:0]  status_q;

  // The output register may take a new result when empty or being drained.
  assign load    = (!valid_q || !out_stall_i) && !q_empty_i;
  assign q_pop_o = load && (sel_q || !q_head_i.two);

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (!valid_q || !out_stall_i) begin
      valid_d = !q_empty_i;
    end
    if (load) begin
      sel_d = !q_pop_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  // Result payload: first part of the head entry, or its trailing header.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sel_q) begin
        word_q   <= q_head_i.word1;
        hdr_q    <= 1'b1;
        end_q    <= 1'b0;
        status_q <= mff_pkg::StatusOk;
        last_q   <= 1'b1;
      end else begin
        word_q   <= q_head_i.word0;
        hdr_q    <= q_head_i.hdr0;
        end_q    <= q_head_i.end0;
        status_q <= q_head_i.status0;
        last_q   <= !q_head_i.two;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign slot_word_o   = word_q;
  assign is_header_o   = hdr_q;
  assign message_end_o = end_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

  `MFF_ASSERT(a_sel_has_entry, sel_q |-> !q_empty_i, "trailing header without a queue entry")
  `MFF_ASSERT(a_err_alone, (valid_q && status_q != mff_pkg::StatusOk) |-> (last_q && !hdr_q),
              "error result is not a lone result")
  `MFF_ASSERT(a_sel_follows, sel_q |-> (valid_q && !hdr_q && !last_q),
              "trailing header not preceded by a data word")

endmodule

`default_nettype wire
